// ----- hdl/flap_button_drive_timer_assert.svh -----
// Assertion helpers for the RTL file flap_button_drive_timer.sv.
`ifndef FLAP_BUTTON_DRIVE_TIMER_ASSERT_SVH
`define FLAP_BUTTON_DRIVE_TIMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FBDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FBDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/fbdt_pkg.sv -----
package fbdt_pkg;

  // Configuration register indexes.
  typedef enum logic [7:0] {
    REG_MAX_DUTY       = 8'd0,
    REG_FLAP_THRESHOLD = 8'd1,
    REG_AUX_THRESHOLD  = 8'd2,
    REG_DRIVE_TICKS    = 8'd3,
    REG_HOLDOFF_TICKS  = 8'd4
  } reg_index_t;

  localparam logic [14:0] MAX_DUTY_RST       = 15'd31130;
  localparam logic [3:0]  FLAP_THRESHOLD_RST = 4'd10;
  localparam logic [2:0]  AUX_THRESHOLD_RST  = 3'd5;
  localparam logic [15:0] DRIVE_TICKS_RST    = 16'd800;
  localparam logic [7:0]  HOLDOFF_TICKS_RST  = 8'd50;

  localparam logic [3:0] FLAP_HOLD_MAX = 4'd15;
  localparam logic [2:0] AUX_HOLD_MAX  = 3'd7;

  localparam int IN_W  = 8;
  localparam int OUT_W = 24;
  localparam int CFG_W = 16;

  // Bit positions in the result word.
  localparam int OUT_DIR_BIT     = 16;
  localparam int OUT_DUTY_BIT    = 17;
  localparam int OUT_CURRENT_BIT = 18;
  localparam int OUT_BRAKE_BIT   = 19;
  localparam int OUT_BLANK_BIT   = 20;

  // Up/down hold counter: up while pressed, saturating at max, down towards zero when released.
  function automatic logic [3:0] hold_step(logic [3:0] cnt, logic pressed, logic [3:0] maxv);
    logic [3:0] res;
    res = cnt;
    if (pressed) begin
      if (cnt < maxv) res = cnt + 4'd1;
    end else if (cnt != 4'd0) begin
      res = cnt - 4'd1;
    end
    return res;
  endfunction

endpackage

// ----- hdl/flap_button_drive_timer.sv -----
// Channel   Direction  Payload                                        Handshake
// in_       slave      flap, rx, pio, remote trigger (one 10 ms tick)  in_tvalid/in_tready
// out_      master     duty, direction, CAN send flags, blanked        out_tvalid/out_tready
// cfg_      slave      register index and write data                   cfg_valid/cfg_ready
//
// Each tick request is worked out combinationally: the hold counters, the
// threshold compares and the drive and holdoff timers form one short path
// from the state registers into the result register.
// One request can be accepted every cycle; the result register is the only stage.
// The input side stalls only while a result is held because out_tready is low.
// Reset (rst_n low, synchronous) clears all timers and counters and loads the
// register defaults; the configuration port is always ready.
`include "flap_button_drive_timer_assert.svh"

module flap_button_drive_timer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [0] flap_pressed, [1] rx_pressed, [2] pio_pressed, [3] remote_trigger, [7:4] zero
  input  logic [fbdt_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [15:0] motor_duty, [16] flap_dir, [17] can_duty_send, [18] can_current_send,
  // [19] can_brake_send, [20] blanked, [23:21] zero
  output logic [fbdt_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_index,
  input  logic [fbdt_pkg::CFG_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [14:0] max_duty_r;
  logic [3:0]  flap_threshold_r;
  logic [2:0]  aux_threshold_r;
  logic [15:0] drive_ticks_r;
  logic [7:0]  holdoff_ticks_r;

  // Tick state.
  logic [3:0]  flap_hold_r, flap_hold_nxt;
  logic [2:0]  rx_hold_r, rx_hold_nxt;
  logic [2:0]  pio_hold_r, pio_hold_nxt;
  logic        direction_r, direction_nxt;
  logic [15:0] drive_left_r, drive_left_nxt;
  logic [9:0]  holdoff_left_r, holdoff_left_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] applied_duty_r, applied_duty_nxt;

  // Result register.
  logic                        out_valid_r;
  logic [fbdt_pkg::OUT_W-1:0]  out_data_r, out_data_nxt;

  logic        accept;
  logic        trig;
  logic        blank;
  logic        fire_flap, fire_rx, fire_pio;
  logic [3:0]  flap_cnt;
  logic [2:0]  rx_cnt, pio_cnt;
  logic [15:0] drive_base;
  logic [15:0] drive_duty;
  logic [9:0]  holdoff_add;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_duty_r       <= fbdt_pkg::MAX_DUTY_RST;
      flap_threshold_r <= fbdt_pkg::FLAP_THRESHOLD_RST;
      aux_threshold_r  <= fbdt_pkg::AUX_THRESHOLD_RST;
      drive_ticks_r    <= fbdt_pkg::DRIVE_TICKS_RST;
      holdoff_ticks_r  <= fbdt_pkg::HOLDOFF_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fbdt_pkg::REG_MAX_DUTY:       max_duty_r       <= cfg_data[14:0];
        fbdt_pkg::REG_FLAP_THRESHOLD: flap_threshold_r <= cfg_data[3:0];
        fbdt_pkg::REG_AUX_THRESHOLD:  aux_threshold_r  <= cfg_data[2:0];
        fbdt_pkg::REG_DRIVE_TICKS:    drive_ticks_r    <= cfg_data;
        fbdt_pkg::REG_HOLDOFF_TICKS:  holdoff_ticks_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    trig  = pending_r || in_tdata[3];
    blank = (holdoff_left_r != 10'd0);

    flap_cnt = fbdt_pkg::hold_step(flap_hold_r, in_tdata[0], fbdt_pkg::FLAP_HOLD_MAX);
    rx_cnt   = 3'(fbdt_pkg::hold_step({1'b0, rx_hold_r}, in_tdata[1],
                                      {1'b0, fbdt_pkg::AUX_HOLD_MAX}));
    pio_cnt  = 3'(fbdt_pkg::hold_step({1'b0, pio_hold_r}, in_tdata[2],
                                      {1'b0, fbdt_pkg::AUX_HOLD_MAX}));

    fire_flap = (flap_cnt > flap_threshold_r) || trig;
    fire_rx   = (rx_cnt > aux_threshold_r);
    fire_pio  = (pio_cnt > aux_threshold_r);

    // Signed drive level for the new direction.
    drive_duty = !direction_r ? {1'b0, max_duty_r} : (16'd0 - {1'b0, max_duty_r});

    drive_base  = fire_flap ? drive_ticks_r : drive_left_r;
    holdoff_add = (fire_flap ? {2'b00, holdoff_ticks_r} : 10'd0)
                + (fire_rx   ? {2'b00, holdoff_ticks_r} : 10'd0)
                + (fire_pio  ? {2'b00, holdoff_ticks_r} : 10'd0);

    // Defaults describe a blanked tick: only the holdoff timer and trigger latch move.
    flap_hold_nxt    = flap_hold_r;
    rx_hold_nxt      = rx_hold_r;
    pio_hold_nxt     = pio_hold_r;
    direction_nxt    = direction_r;
    drive_left_nxt   = drive_left_r;
    applied_duty_nxt = applied_duty_r;
    pending_nxt      = trig;
    holdoff_left_nxt = holdoff_left_r - 10'd1;

    if (!blank) begin
      flap_hold_nxt    = fire_flap ? 4'd0 : flap_cnt;
      rx_hold_nxt      = fire_rx   ? 3'd0 : rx_cnt;
      pio_hold_nxt     = fire_pio  ? 3'd0 : pio_cnt;
      pending_nxt      = 1'b0;
      direction_nxt    = direction_r ^ fire_flap;
      holdoff_left_nxt = holdoff_add;
      drive_left_nxt   = (drive_base != 16'd0) ? drive_base - 16'd1 : 16'd0;
      if (drive_left_nxt == 16'd0) begin
        applied_duty_nxt = 16'd0;
      end else if (fire_flap) begin
        applied_duty_nxt = drive_duty;
      end
    end

    out_data_nxt = '0;
    out_data_nxt[15:0]                      = applied_duty_nxt;
    out_data_nxt[fbdt_pkg::OUT_DIR_BIT]     = direction_nxt;
    out_data_nxt[fbdt_pkg::OUT_DUTY_BIT]    = !blank && fire_flap;
    out_data_nxt[fbdt_pkg::OUT_CURRENT_BIT] = !blank && fire_rx;
    out_data_nxt[fbdt_pkg::OUT_BRAKE_BIT]   = !blank && fire_pio;
    out_data_nxt[fbdt_pkg::OUT_BLANK_BIT]   = blank;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flap_hold_r    <= '0;
      rx_hold_r      <= '0;
      pio_hold_r     <= '0;
      direction_r    <= 1'b0;
      drive_left_r   <= '0;
      holdoff_left_r <= '0;
      pending_r      <= 1'b0;
      applied_duty_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        flap_hold_r    <= flap_hold_nxt;
        rx_hold_r      <= rx_hold_nxt;
        pio_hold_r     <= pio_hold_nxt;
        direction_r    <= direction_nxt;
        drive_left_r   <= drive_left_nxt;
        holdoff_left_r <= holdoff_left_nxt;
        pending_r      <= pending_nxt;
        applied_duty_r <= applied_duty_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_tready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  // The result word carries no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  // A request taken during holdoff comes out marked as blanked.
  `FBDT_ASSERT_NEXT(a_holdoff_blanks, clk, rst_n, accept && (holdoff_left_r != 10'd0),
    out_valid_r && out_data_r[fbdt_pkg::OUT_BLANK_BIT], "holdoff tick not blanked")

  // A blanked result never asks for a CAN send.
  `FBDT_ASSERT_NOW(a_blank_quiet, clk, rst_n,
    out_valid_r && out_data_r[fbdt_pkg::OUT_BLANK_BIT],
    !out_data_r[fbdt_pkg::OUT_DUTY_BIT] && !out_data_r[fbdt_pkg::OUT_CURRENT_BIT]
      && !out_data_r[fbdt_pkg::OUT_BRAKE_BIT], "send flag on blanked tick")

  // The motor is only driven while the drive window is open.
  `FBDT_ASSERT_NOW(a_duty_in_window, clk, rst_n, applied_duty_r != 16'd0,
    drive_left_r != 16'd0, "duty applied outside drive window")

  // A remote trigger outside holdoff toggles at once.
  `FBDT_ASSERT_NEXT(a_remote_serves, clk, rst_n,
    accept && (holdoff_left_r == 10'd0) && in_tdata[3],
    out_data_r[fbdt_pkg::OUT_DUTY_BIT] && !pending_r, "remote trigger not served")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the flap and aux button drive timer. Every tick request
// taken by the block runs through a local model of the hold counters, the drive
// window and the holdoff blanking; the prediction is queued and compared field by
// field with the next result that leaves the block. Settings change only while
// the block is idle, between phases.
module tb;

  // Index that selects no register; writes to it must leave every setting alone.
  localparam logic [7:0] REG_NONE = 8'd200;
  // Cycles without any handshake before the run is declared hung. The longest
  // correct pause is a few sender and receiver idles plus the settle between phases.
  localparam int QUIET_LIMIT = 2000;
  // Tick requests offered in each random phase.
  localparam int PHASE_TICKS = 100;

  // One tick request as it travels in in_tdata, flap button in bit 0.
  typedef struct packed {
    logic [3:0] spare;
    logic       remote;
    logic       pio;
    logic       rx;
    logic       flap;
  } tick_t;

  // One result as it travels in out_tdata, duty in the low 16 bits.
  typedef struct packed {
    logic [2:0]  spare;
    logic        blanked;
    logic        brake_send;
    logic        current_send;
    logic        duty_send;
    logic        dir;
    logic [15:0] duty;
  } tick_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  tick_t                         in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [fbdt_pkg::OUT_W-1:0]    out_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [7:0]                    cfg_index = '0;
  logic [fbdt_pkg::CFG_W-1:0]    cfg_data = '0;

  flap_button_drive_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Tick requests waiting to be offered, and the results they are expected to give.
  tick_t        pending_ticks[$];
  tick_result_t expected_results[$];

  // Whether each side idles at random in the current phase.
  logic idle_in = 1'b0;
  logic idle_out = 1'b0;

  int fail_count = 0;

  // Shadow copy of the settings, loaded with the reset values.
  logic [14:0] set_max_duty  = fbdt_pkg::MAX_DUTY_RST;
  logic [3:0]  set_flap_thr  = fbdt_pkg::FLAP_THRESHOLD_RST;
  logic [2:0]  set_aux_thr   = fbdt_pkg::AUX_THRESHOLD_RST;
  logic [15:0] set_drive     = fbdt_pkg::DRIVE_TICKS_RST;
  logic [7:0]  set_holdoff   = fbdt_pkg::HOLDOFF_TICKS_RST;

  // Model state, all clear after reset.
  logic [3:0]  flap_count = '0;
  logic [2:0]  rx_count = '0;
  logic [2:0]  pio_count = '0;
  logic        flap_dir = 1'b0;
  logic [15:0] drive_remaining = '0;
  logic [9:0]  blank_remaining = '0;
  logic        toggle_latched = 1'b0;
  logic [15:0] duty_now = '0;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // A hold counter climbs while its button is held, saturating at the ceiling,
  // and falls back towards zero once the button is let go.
  function automatic logic [3:0] bump_hold(input logic [3:0] count, input logic pressed,
                                           input logic [3:0] ceiling);
    if (pressed) return (count < ceiling) ? count + 4'd1 : count;
    return (count != 4'd0) ? count - 4'd1 : count;
  endfunction

  // Works out the result of one accepted tick and queues it.
  task automatic predict_tick(input tick_t t);
    tick_result_t r;
    r = '0;
    // The remote toggle is latched even on a blanked tick and served later.
    if (t.remote) toggle_latched = 1'b1;
    if (blank_remaining != '0) begin
      // Blanked: only the holdoff count moves, duty and direction hold.
      blank_remaining = blank_remaining - 10'd1;
      r.blanked = 1'b1;
    end else begin
      flap_count = bump_hold(flap_count, t.flap, fbdt_pkg::FLAP_HOLD_MAX);
      rx_count = 3'(bump_hold({1'b0, rx_count}, t.rx, {1'b0, fbdt_pkg::AUX_HOLD_MAX}));
      pio_count = 3'(bump_hold({1'b0, pio_count}, t.pio, {1'b0, fbdt_pkg::AUX_HOLD_MAX}));
      if (flap_count > set_flap_thr || toggle_latched) begin
        flap_count = '0;
        toggle_latched = 1'b0;
        flap_dir = ~flap_dir;
        drive_remaining = set_drive;
        duty_now = flap_dir ? {1'b0, set_max_duty} : -{1'b0, set_max_duty};
        r.duty_send = 1'b1;
        blank_remaining = blank_remaining + set_holdoff;
      end
      if (rx_count > set_aux_thr) begin
        rx_count = '0;
        r.current_send = 1'b1;
        blank_remaining = blank_remaining + set_holdoff;
      end
      if (pio_count > set_aux_thr) begin
        pio_count = '0;
        r.brake_send = 1'b1;
        blank_remaining = blank_remaining + set_holdoff;
      end
      // A window of zero or one tick closes on the firing tick itself.
      if (drive_remaining != '0) drive_remaining = drive_remaining - 16'd1;
      if (drive_remaining == '0) duty_now = '0;
    end
    r.duty = duty_now;
    r.dir = flap_dir;
    expected_results.push_back(r);
  endtask

  // Sender: offers queued tick requests, with a random pause after each one when idle_in is set.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) predict_tick(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_tvalid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_ticks.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_ticks.pop_front();
          in_gap <= idle_in ? $urandom_range(0, 3) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Receiver: takes results, compares them with the oldest prediction and then,
  // when idle_out is set, holds out_tready low for a random number of cycles, possibly none.
  int out_wait = 0;
  always @(posedge clk) begin : result_check
    tick_result_t got, want;
    int unsigned stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait <= 0;
    end else if (out_tvalid && out_tready) begin
      got = tick_result_t'(out_tdata);
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no tick request outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("motor_duty", got.duty, want.duty);
        check_field("flap_dir", 16'(got.dir), 16'(want.dir));
        check_field("can_duty_send", 16'(got.duty_send), 16'(want.duty_send));
        check_field("can_current_send", 16'(got.current_send), 16'(want.current_send));
        check_field("can_brake_send", 16'(got.brake_send), 16'(want.brake_send));
        check_field("blanked", 16'(got.blanked), 16'(want.blanked));
      end
      stall = idle_out ? $urandom_range(0, 3) : 0;
      out_tready <= (stall == 0);
      out_wait <= stall;
    end else if (out_wait != 0) begin
      out_tready <= (out_wait == 1);
      out_wait <= out_wait - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Setting writes update the shadow copy; values are cut to the register widths.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbdt_pkg::REG_MAX_DUTY:       set_max_duty = cfg_data[14:0];
        fbdt_pkg::REG_FLAP_THRESHOLD: set_flap_thr = cfg_data[3:0];
        fbdt_pkg::REG_AUX_THRESHOLD:  set_aux_thr = cfg_data[2:0];
        fbdt_pkg::REG_DRIVE_TICKS:    set_drive = cfg_data[15:0];
        fbdt_pkg::REG_HOLDOFF_TICKS:  set_holdoff = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Watchdog: a long stretch with no request moving on any channel means a hang.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Raises a write request and waits for it to be taken; cfg_valid stays high
  // so that back-to-back writes need no second assignment in one step.
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_tick(input logic [3:0] buttons);
    pending_ticks.push_back(tick_t'({4'b0000, buttons}));
  endtask

  // Idle means nothing queued, nothing offered and no result outstanding. The
  // result register is the only stage, so the wait that follows settles everything.
  task automatic wait_idle();
    while (pending_ticks.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    tick_t       t;
    logic [2:0]  held;
    int          run_len;
    int          sent;
    logic [14:0] md;
    logic [3:0]  ft;
    logic [2:0]  at;
    logic [15:0] dt;
    logic [7:0]  ht;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, first set: zero thresholds, a one-tick drive window and no
    // holdoff. The written values other than the drive window carry stray upper bits that must be cut off,
    // and a write to an unused index must change nothing.
    write_reg(fbdt_pkg::REG_MAX_DUTY, 16'hFFFF);
    write_reg(fbdt_pkg::REG_FLAP_THRESHOLD, 16'h00F0);
    write_reg(fbdt_pkg::REG_AUX_THRESHOLD, 16'h0008);
    write_reg(fbdt_pkg::REG_DRIVE_TICKS, 16'd1);
    write_reg(fbdt_pkg::REG_HOLDOFF_TICKS, 16'hFF00);
    write_reg(REG_NONE, 16'h0003);
    end_writes();
    push_tick(4'b0000);
    push_tick(4'b0001);   // single flap press fires, window closes at once
    push_tick(4'b0010);
    push_tick(4'b0100);
    push_tick(4'b1000);   // remote toggle
    push_tick(4'b1111);
    push_tick(4'b0000);
    wait_idle();

    // Directed, second set: top thresholds that a saturated counter can never
    // pass, a zero drive window, zero duty and a one-tick holdoff.
    idle_in = 1'b1;
    idle_out = 1'b1;
    write_reg(fbdt_pkg::REG_MAX_DUTY, 16'd0);
    write_reg(fbdt_pkg::REG_FLAP_THRESHOLD, 16'd15);
    write_reg(fbdt_pkg::REG_AUX_THRESHOLD, 16'd7);
    write_reg(fbdt_pkg::REG_DRIVE_TICKS, 16'd0);
    write_reg(fbdt_pkg::REG_HOLDOFF_TICKS, 16'd1);
    end_writes();
    repeat (17) push_tick(4'b0111);
    push_tick(4'b1000);   // remote fires, next tick is blanked
    push_tick(4'b1000);   // blanked, but the toggle is latched
    push_tick(4'b0000);   // latched toggle served
    wait_idle();

    // Random phases. Most use short windows and holdoffs so that the counters
    // and timers are exercised often; a few use the extremes.
    held = '0;
    for (int ph = 0; ph < 12; ph++) begin
      md = (ph == 0) ? 15'd0 : (ph == 1) ? 15'h7FFF : 15'($urandom);
      ft = (ph == 2) ? 4'd15 : (ph == 3) ? 4'd1 : 4'($urandom_range(0, 12));
      at = (ph == 2) ? 3'd7 : (ph == 3) ? 3'd1 : 3'($urandom_range(0, 6));
      dt = (ph == 4) ? 16'hFFFF : (ph == 5) ? 16'd1 : (ph == 6) ? 16'd0 :
           16'($urandom_range(1, 40));
      ht = (ph == 7) ? 8'hFF : (ph == 8) ? 8'd0 : 8'($urandom_range(0, 6));
      if (ph == 9) begin
        // Back to the reset values.
        md = fbdt_pkg::MAX_DUTY_RST;
        ft = fbdt_pkg::FLAP_THRESHOLD_RST;
        at = fbdt_pkg::AUX_THRESHOLD_RST;
        dt = fbdt_pkg::DRIVE_TICKS_RST;
        ht = fbdt_pkg::HOLDOFF_TICKS_RST;
      end
      write_reg(fbdt_pkg::REG_MAX_DUTY, {1'($urandom), md});
      write_reg(fbdt_pkg::REG_FLAP_THRESHOLD, {12'($urandom), ft});
      write_reg(fbdt_pkg::REG_AUX_THRESHOLD, {13'($urandom), at});
      write_reg(fbdt_pkg::REG_DRIVE_TICKS, dt);
      write_reg(fbdt_pkg::REG_HOLDOFF_TICKS, {8'($urandom), ht});
      end_writes();

      idle_in = (ph % 4 != 1);
      idle_out = (ph % 4 != 2);
      run_len = $urandom_range(3, 18);
      // A fixed number of ticks per phase; with long holdoffs most of them are blanked.
      sent = 0;
      while (sent < PHASE_TICKS) begin
        if (pending_ticks.size() < 2) begin
          if ($urandom_range(0, 4) == 0) begin
            // Noise: any button pattern, breaking up the held runs.
            t = tick_t'(8'($urandom_range(0, 15)));
          end else begin
            // Buttons are held in runs so the counters climb past their thresholds.
            for (int b = 0; b < 3; b++)
              if ($urandom_range(0, run_len) == 0) held[b] = ~held[b];
            t = '0;
            t.flap = held[0];
            t.rx = held[1];
            t.pio = held[2];
            t.remote = ($urandom_range(0, 29) == 0);
          end
          pending_ticks.push_back(t);
          sent++;
        end
        @(posedge clk);
      end
      wait_idle();
    end

    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
